// ----- design/kwms_pkg.sv -----
// ----------------------------------------------------------------------------
// kwms_pkg
// Shared widths, codes and control/status bundles of the K-weighted meter.
// ----------------------------------------------------------------------------
package kwms_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 28;
  localparam int COUNT_W    = 24;
  localparam int CNT_W      = COUNT_W + 1;
  localparam int Y_W        = SAMPLE_W + 1;            // Q2.23 stage output
  localparam int PROD_W     = COEF_W + Y_W;
  localparam int PROD_SHIFT = 7;
  localparam int F_W        = PROD_W - PROD_SHIFT;
  localparam int STATE_W    = 48;
  localparam int STAGE_SHIFT = (COEF_W - 4) - PROD_SHIFT;
  localparam int SH_W       = STATE_W + 1 - STAGE_SHIFT;
  localparam int SQ_SHIFT   = 2 * (SAMPLE_W - 1) - 36;
  localparam int SQ_W       = 2 * SAMPLE_W + 1 - SQ_SHIFT;
  localparam int SUM_W      = 64;
  localparam int MS_W       = 40;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int DIV_CNT_W  = 6;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_arr_t [NUM_REGS];

  typedef enum logic [2:0] {
    REG_SHELF_B0, REG_SHELF_B1, REG_SHELF_B2, REG_SHELF_A1,
    REG_SHELF_A2, REG_HP_GAIN, REG_HP_A1, REG_HP_A2
  } reg_idx_t;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    28'sd25755121, -28'sd45159168, 28'sd20105693, -28'sd28364556,
    28'sd12288990, 28'sd16777216, -28'sd33387456, 28'sd16610656
  };

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DRY   = 2'd1,
    CMD_WET   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {OPND_X, OPND_Y, OPND_SQ} opnd_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_Y, OP_T0, OP_T1, OP_S0, OP_S1, OP_HP, OP_ACC
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_B0, ST_B1, ST_B2, ST_SA1, ST_SA2, ST_G, ST_HY, ST_HA1,
    ST_HA2, ST_SQ, ST_ACC, ST_CHK, ST_DIV_DRY, ST_WAIT_DRY, ST_DIV_WET,
    ST_WAIT_WET, ST_OUT
  } state_t;

  typedef struct packed {
    reg_idx_t coef;
    opnd_t    opnd;
    dp_op_t   op;
    logic     stage_hp;
    logic     load;
    logic     ch_wet;
    logic     clear;
    logic     div_start;
    logic     div_wet;
    logic     cap_dry;
    logic     cap_wet;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic wet_full;
    logic wet_zero;
    logic dry_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- design/kwms_regs.sv -----
// ----------------------------------------------------------------------------
// kwms_regs
// Coefficient register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module kwms_regs import kwms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output coef_arr_t         coefs
);

  coef_t coef_r [NUM_REGS];
  logic  wr_en;
  logic [2:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coef_r[i] <= COEF_RESET[i];
    end else if (wr_en) begin
      coef_r[idx] <= pwdata[COEF_W-1:0];
    end
  end

  assign prdata = {{(DATA_W-COEF_W){coef_r[idx][COEF_W-1]}}, coef_r[idx]};

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) coefs[i] = coef_r[i];
  end

endmodule

// ----- design/kwms_div.sv -----
// ----------------------------------------------------------------------------
// kwms_div
// Restoring divider, one quotient bit per cycle, for the mean of a sum.
// ----------------------------------------------------------------------------
module kwms_div import kwms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [MS_W-1:0]  quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W:0]       shifted;
  logic [CNT_W+1:0]     diff;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      cnt_r <= '1;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (!diff[CNT_W+1]) begin
        rem_r <= diff[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[MS_W-1:0];

endmodule

// ----- design/kwms_dp.sv -----
// ----------------------------------------------------------------------------
// kwms_dp
// Datapath: shared multiplier, biquad states, square sums, counts, output.
// ----------------------------------------------------------------------------
module kwms_dp import kwms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_t                      ctrl,
  output stat_t                      stat,
  input  coef_arr_t                  coefs,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [COUNT_W-1:0]         in_record_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MS_W-1:0]            out_dry_mean_square,
  output logic [MS_W-1:0]            out_wet_mean_square
);

  logic signed [SAMPLE_W-1:0] x_r;
  logic                       ch_r;
  logic signed [Y_W-1:0]      y_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [STATE_W-1:0]  tmp0_r, tmp1_r;
  logic signed [STATE_W-1:0]  sh_s0_r [2];
  logic signed [STATE_W-1:0]  sh_s1_r [2];
  logic signed [STATE_W-1:0]  hp_s0_r [2];
  logic signed [STATE_W-1:0]  hp_s1_r [2];
  logic [SUM_W-1:0]           sum_r [2];
  logic [CNT_W-1:0]           cnt_r [2];
  logic [COUNT_W-1:0]         target_r;
  logic [MS_W-1:0]            q_dry_r, q_wet_r;
  logic                       out_valid_r;
  logic [MS_W-1:0]            out_dry_r, out_wet_r;

  logic signed [COEF_W-1:0]   a_op;
  logic signed [Y_W-1:0]      b_op;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [STATE_W-1:0]  f48, s0_cur, s1_cur;
  logic signed [STATE_W:0]    acc_sum;
  logic [SH_W-1:0]            shifted;
  logic [SH_W-Y_W:0]          top;
  logic signed [Y_W-1:0]      y_sat;
  logic [SQ_W-1:0]            sq;
  logic                       div_done;
  logic [MS_W-1:0]            div_q;

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.opnd)
      OPND_X: begin
        a_op = coefs[ctrl.coef];
        b_op = {x_r[SAMPLE_W-1], x_r};
      end
      OPND_Y: begin
        a_op = coefs[ctrl.coef];
        b_op = y_r;
      end
      OPND_SQ: begin
        a_op = {{(COEF_W-Y_W){y_r[Y_W-1]}}, y_r};
        b_op = y_r;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_nxt = a_op * b_op;
  // exact product floored by 2^7 into state format
  assign f48 = {{(STATE_W-F_W){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:PROD_SHIFT]};

  assign s0_cur = ctrl.stage_hp ? hp_s0_r[ch_r] : sh_s0_r[ch_r];
  assign s1_cur = ctrl.stage_hp ? hp_s1_r[ch_r] : sh_s1_r[ch_r];

  // stage output: floor to 23 fraction bits, saturate to Q2.23
  assign acc_sum = {f48[STATE_W-1], f48} + {s0_cur[STATE_W-1], s0_cur};
  assign shifted = acc_sum[STATE_W:STAGE_SHIFT];
  assign top     = shifted[SH_W-1:Y_W-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      y_sat = shifted[Y_W-1:0];
    end else if (shifted[SH_W-1]) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  assign sq = prod_r[2*SAMPLE_W:SQ_SHIFT];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctrl.load) begin
      x_r  <= in_sample;
      ch_r <= ctrl.ch_wet;
    end
    if (ctrl.clear) begin
      for (int i = 0; i < 2; i++) begin
        sh_s0_r[i] <= '0;
        sh_s1_r[i] <= '0;
        hp_s0_r[i] <= '0;
        hp_s1_r[i] <= '0;
        sum_r[i]   <= '0;
        cnt_r[i]   <= '0;
      end
      target_r <= in_record_length;
    end else begin
      case (ctrl.op)
        OP_Y:  y_r <= y_sat;
        OP_T0: tmp0_r <= f48 + s1_cur;
        OP_T1: tmp1_r <= f48;
        OP_S0: begin
          if (ctrl.stage_hp) hp_s0_r[ch_r] <= tmp0_r - f48;
          else sh_s0_r[ch_r] <= tmp0_r - f48;
        end
        OP_S1: begin
          if (ctrl.stage_hp) hp_s1_r[ch_r] <= tmp1_r - f48;
          else sh_s1_r[ch_r] <= tmp1_r - f48;
        end
        OP_HP: begin
          // high-pass taps t, -2t, t
          y_r    <= y_sat;
          tmp0_r <= s1_cur - (f48 <<< 1);
          tmp1_r <= f48;
        end
        OP_ACC: begin
          sum_r[ch_r] <= sum_r[ch_r] + {{(SUM_W-SQ_W){1'b0}}, sq};
          cnt_r[ch_r] <= cnt_r[ch_r] + 1'b1;
        end
        default: ;
      endcase
    end
    if (ctrl.cap_dry) q_dry_r <= div_q;
    if (ctrl.cap_wet) q_wet_r <= (cnt_r[1] == '0) ? '0 : div_q;
  end

  kwms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (ctrl.div_wet ? sum_r[1] : sum_r[0]),
    .divisor  (ctrl.div_wet ? cnt_r[1] : cnt_r[0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_dry_r <= q_dry_r;
      out_wet_r <= q_wet_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dry_mean_square = out_dry_r;
  assign out_wet_mean_square = out_wet_r;

  assign stat.wet_full = &cnt_r[1];
  assign stat.wet_zero = cnt_r[1] == '0;
  assign stat.dry_done = cnt_r[0] >= {1'b0, target_r};
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ----- design/kwms_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwms_ctrl
// Sequencer: input handshake, per-sample multiply schedule, end of record.
// ----------------------------------------------------------------------------
module kwms_ctrl import kwms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  stat_t      stat,
  output ctrl_t      ctrl
);

  state_t state_r, state_nxt;
  logic   rec_r, rec_nxt;
  logic   wet_r, wet_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rec_r   <= 1'b0;
      wet_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rec_r   <= rec_nxt;
      wet_r   <= wet_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rec_nxt   = rec_r;
    wet_nxt   = wet_r;
    ctrl      = '0;
    ctrl.coef = REG_SHELF_B0;
    ctrl.opnd = OPND_X;
    ctrl.op   = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_command)
            CMD_START: begin
              ctrl.clear = 1'b1;
              rec_nxt    = 1'b1;
            end
            CMD_DRY: begin
              if (rec_r) begin
                ctrl.load = 1'b1;
                wet_nxt   = 1'b0;
                state_nxt = ST_B0;
              end
            end
            CMD_WET: begin
              if (rec_r && !stat.wet_full) begin
                ctrl.load   = 1'b1;
                ctrl.ch_wet = 1'b1;
                wet_nxt     = 1'b1;
                state_nxt   = ST_B0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_B0: begin
        ctrl.coef = REG_SHELF_B0;
        state_nxt = ST_B1;
      end
      ST_B1: begin
        ctrl.coef = REG_SHELF_B1;
        ctrl.op   = OP_Y;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        ctrl.coef = REG_SHELF_B2;
        ctrl.op   = OP_T0;
        state_nxt = ST_SA1;
      end
      ST_SA1: begin
        ctrl.coef = REG_SHELF_A1;
        ctrl.opnd = OPND_Y;
        ctrl.op   = OP_T1;
        state_nxt = ST_SA2;
      end
      ST_SA2: begin
        ctrl.coef = REG_SHELF_A2;
        ctrl.opnd = OPND_Y;
        ctrl.op   = OP_S0;
        state_nxt = ST_G;
      end
      ST_G: begin
        ctrl.coef = REG_HP_GAIN;
        ctrl.opnd = OPND_Y;
        ctrl.op   = OP_S1;
        state_nxt = ST_HY;
      end
      ST_HY: begin
        ctrl.op       = OP_HP;
        ctrl.stage_hp = 1'b1;
        state_nxt     = ST_HA1;
      end
      ST_HA1: begin
        ctrl.coef     = REG_HP_A1;
        ctrl.opnd     = OPND_Y;
        ctrl.stage_hp = 1'b1;
        state_nxt     = ST_HA2;
      end
      ST_HA2: begin
        ctrl.coef     = REG_HP_A2;
        ctrl.opnd     = OPND_Y;
        ctrl.op       = OP_S0;
        ctrl.stage_hp = 1'b1;
        state_nxt     = ST_SQ;
      end
      ST_SQ: begin
        ctrl.opnd     = OPND_SQ;
        ctrl.op       = OP_S1;
        ctrl.stage_hp = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        ctrl.op   = OP_ACC;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // wet beats never end a record; dry count is untouched by them
        state_nxt = ST_IDLE;
        if (stat.dry_done && !wet_r) state_nxt = ST_DIV_DRY;
      end
      ST_DIV_DRY: begin
        ctrl.div_start = 1'b1;
        state_nxt      = ST_WAIT_DRY;
      end
      ST_WAIT_DRY: begin
        if (stat.div_done) begin
          ctrl.cap_dry = 1'b1;
          state_nxt    = ST_DIV_WET;
        end
      end
      ST_DIV_WET: begin
        ctrl.div_wet = 1'b1;
        if (stat.wet_zero) begin
          ctrl.cap_wet = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          ctrl.div_start = 1'b1;
          state_nxt      = ST_WAIT_WET;
        end
      end
      ST_WAIT_WET: begin
        ctrl.div_wet = 1'b1;
        if (stat.div_done) begin
          ctrl.cap_wet = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          rec_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- design/k_weighted_mean_square_meter_unit.sv -----
// ----------------------------------------------------------------------------
// k_weighted_mean_square_meter_unit
// K-weighted mean-square meter for a dry and a wet audio channel.
// ----------------------------------------------------------------------------
// Input beats carry a command (start, dry sample, wet sample), a Q1.23
// sample and a record length; a beat is taken when in_valid is high and
// in_stall is low. Start clears filters, sums and counts and arms the meter.
// Each sample runs through a high shelf and a high pass biquad on one shared
// 28x25 multiplier, then its square is added to the channel sum; start and
// ignored beats are taken without running the filters.
// When the dry count reaches the record length, the dry sum and then the wet
// sum are divided by a 64-step restoring divider (the wet mean square is zero
// without division when no wet sample arrived), and a result beat follows.
// The result sits in an output register until out_stall is low; new input
// beats are taken meanwhile, and a further result waits for the register.
// Coefficients are written over the APB-style port while the meter is idle;
// the user must keep to this, as the block does not enforce it. After reset
// the meter is idle with default coefficients; samples are ignored until a
// start beat arrives.
// ----------------------------------------------------------------------------
module k_weighted_mean_square_meter_unit import kwms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [COUNT_W-1:0]         in_record_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MS_W-1:0]            out_dry_mean_square,
  output logic [MS_W-1:0]            out_wet_mean_square,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  coef_arr_t coefs;
  ctrl_t     ctrl;
  stat_t     stat;

  kwms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  kwms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  kwms_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .stat                (stat),
    .coefs               (coefs),
    .in_sample           (in_sample),
    .in_record_length    (in_record_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dry_mean_square (out_dry_mean_square),
    .out_wet_mean_square (out_wet_mean_square)
  );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the K-weighted mean-square meter.
// ----------------------------------------------------------------------------
// Beats come from a queue that the stimulus process fills. A clocked driver
// offers them with random idle bursts. A clocked monitor predicts the two
// mean squares from every accepted beat and checks each result beat in
// order. Coefficients are rewritten over the register port between phases:
// defaults, random values, extremes, then random again with no idling.
// ----------------------------------------------------------------------------
module tb_top;
  import kwms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [1:0]          cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [COUNT_W-1:0]  len;
  } beat_t;

  typedef struct {
    logic [MS_W-1:0] dry_ms;
    logic [MS_W-1:0] wet_ms;
  } meas_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_command;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [COUNT_W-1:0] in_record_length;
  logic out_valid;
  logic out_stall;
  logic [MS_W-1:0] out_dry_mean_square;
  logic [MS_W-1:0] out_wet_mean_square;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  k_weighted_mean_square_meter_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_sample(in_sample), .in_record_length(in_record_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dry_mean_square(out_dry_mean_square),
    .out_wet_mean_square(out_wet_mean_square),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  beat_t pending_beats[$];
  meas_t expected_meas[$];
  int mismatches = 0;
  bit quiet = 0;
  bit hold_off = 0;
  bit hold_go = 0;
  bit in_taken = 0;
  int in_gap = 0;
  int out_gap = 0;
  int cycle_count = 0;

  // predictor state: coefficients, per channel {shelf s0, s1, hp s0, s1}
  longint coef [NUM_REGS];
  longint flt [2][4];
  logic [63:0] sq_sum [2];
  logic [CNT_W-1:0] cnt [2];
  logic [COUNT_W-1:0] target_len;
  bit recording;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint sat_q2(longint v);
    longint hi;
    hi = (longint'(1) <<< SAMPLE_W) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // floor(c*v / 2^7); products stay well inside 64 bits
  function automatic longint scaled(longint c, longint v);
    return (c * v) >>> PROD_SHIFT;
  endfunction

  function automatic longint biquad(int ch, int base, longint f0, longint f1,
                                    longint f2, longint a1, longint a2);
    longint y;
    y = sat_q2((f0 + flt[ch][base]) >>> STAGE_SHIFT);
    flt[ch][base] = f1 - scaled(a1, y) + flt[ch][base+1];
    flt[ch][base+1] = f2 - scaled(a2, y);
    return y;
  endfunction

  function automatic logic [63:0] weighted_square(int ch, longint x);
    longint y1, t, y2;
    logic [63:0] mag;
    y1 = biquad(ch, 0, scaled(coef[REG_SHELF_B0], x), scaled(coef[REG_SHELF_B1], x),
                scaled(coef[REG_SHELF_B2], x), coef[REG_SHELF_A1], coef[REG_SHELF_A2]);
    t = scaled(coef[REG_HP_GAIN], y1);
    y2 = biquad(ch, 2, t, -2 * t, t, coef[REG_HP_A1], coef[REG_HP_A2]);
    mag = (y2 < 0) ? -y2 : y2;
    return (mag * mag) >> SQ_SHIFT;
  endfunction

  task automatic meter_step(beat_t b);
    int ch;
    longint x;
    meas_t m;
    x = longint'($signed(b.smp));
    if (b.cmd == CMD_START) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 4; k++) flt[c][k] = 0;
        sq_sum[c] = 0;
        cnt[c] = 0;
      end
      target_len = b.len;
      recording = 1;
    end else if (recording && b.cmd != CMD_UNUSED) begin
      ch = (b.cmd == CMD_WET) ? 1 : 0;
      if (!(ch == 1 && cnt[1] == {CNT_W{1'b1}})) begin
        sq_sum[ch] = sq_sum[ch] + weighted_square(ch, x);
        cnt[ch] = cnt[ch] + 1'b1;
        if (ch == 0 && cnt[0] >= target_len) begin
          m.dry_ms = MS_W'(sq_sum[0] / 64'(cnt[0]));
          m.wet_ms = (cnt[1] != 0) ? MS_W'(sq_sum[1] / 64'(cnt[1])) : '0;
          expected_meas.push_back(m);
          recording = 0;
        end
      end
    end
  endtask

  // input monitor and result checker
  always @(posedge clk) begin
    meas_t e;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      meter_step('{in_command, in_sample, in_record_length});
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_meas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat dry=%h wet=%h",
                   out_dry_mean_square, out_wet_mean_square);
      end else begin
        e = expected_meas.pop_front();
        if (e.dry_ms !== out_dry_mean_square || e.wet_ms !== out_wet_mean_square) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: dry exp %h got %h, wet exp %h got %h",
                     e.dry_ms, out_dry_mean_square, e.wet_ms, out_wet_mean_square);
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    beat_t b;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 15);
        in_valid <= 0;
      end else if (pending_beats.size() != 0) begin
        b = pending_beats.pop_front();
        in_command <= b.cmd;
        in_sample <= b.smp;
        in_record_length <= b.len;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 15);
      out_stall <= 1;
    end else begin
      out_stall <= hold_off;
    end
  end

  // long receiver hold-off so the result register and input back up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 0;
  end

  task automatic reg_write(reg_idx_t idx, longint val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= DATA_W'(val);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    coef[idx] = longint'($signed(COEF_W'(val)));
    @(negedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic beat_t mk(logic [1:0] c, logic [SAMPLE_W-1:0] s,
                               logic [COUNT_W-1:0] l);
    beat_t b;
    b.cmd = c;
    b.smp = s;
    b.len = l;
    return b;
  endfunction

  // one measurement: start, then a mix of dry and wet beats, some noise
  task automatic add_measurement();
    int len, dry_left;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    if ($urandom_range(0, 7) == 0) begin
      // broken sequence: a long record that is restarted midway
      pending_beats.push_back(mk(CMD_START, SAMPLE_W'($urandom), COUNT_W'($urandom)));
      repeat ($urandom_range(0, 4))
        pending_beats.push_back(mk(2'($urandom_range(1, 3)), pick_sample(),
                                   COUNT_W'($urandom)));
    end
    pending_beats.push_back(mk(CMD_START, SAMPLE_W'($urandom), COUNT_W'(len)));
    dry_left = (len == 0) ? 1 : len;
    while (dry_left > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending_beats.push_back(mk(CMD_WET, pick_sample(), COUNT_W'($urandom)));
        3: pending_beats.push_back(mk(CMD_UNUSED, pick_sample(), COUNT_W'($urandom)));
        default: begin
          pending_beats.push_back(mk(CMD_DRY, pick_sample(), COUNT_W'($urandom)));
          dry_left--;
        end
      endcase
    end
    // idle samples after the result
    if ($urandom_range(0, 3) == 0)
      pending_beats.push_back(mk(2'($urandom_range(1, 2)), pick_sample(),
                                 COUNT_W'($urandom)));
  endtask

  task automatic settle();
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_meas.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int items);
    int goal;
    goal = pending_beats.size() + items;
    while (pending_beats.size() < goal) add_measurement();
  endtask

  initial begin
    logic [SAMPLE_W-1:0] pmax, nmax;
    pmax = {1'b0, {(SAMPLE_W-1){1'b1}}};
    nmax = {1'b1, {(SAMPLE_W-1){1'b0}}};
    for (int i = 0; i < NUM_REGS; i++) coef[i] = COEF_RESET[i];
    recording = 0;
    target_len = 0;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 4; k++) flt[c][k] = 0;
      sq_sum[c] = 0;
      cnt[c] = 0;
    end
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_START;
    in_sample = '0;
    in_record_length = '0;
    out_stall = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // defaults written explicitly
    for (int i = 0; i < NUM_REGS; i++) reg_write(reg_idx_t'(i), COEF_RESET[i]);

    // directed beats
    pending_beats.push_back(mk(CMD_DRY, pmax, '0));           // ignored while idle
    pending_beats.push_back(mk(CMD_START, '0, 24'd3));
    pending_beats.push_back(mk(CMD_DRY, pmax, '0));
    pending_beats.push_back(mk(CMD_WET, nmax, '0));
    pending_beats.push_back(mk(CMD_UNUSED, pmax, '1));
    pending_beats.push_back(mk(CMD_DRY, '0, '0));
    pending_beats.push_back(mk(CMD_WET, pmax, '0));
    pending_beats.push_back(mk(CMD_DRY, nmax, '0));
    pending_beats.push_back(mk(CMD_WET, nmax, '0));           // idle again
    pending_beats.push_back(mk(CMD_START, '1, 24'd0));        // zero length
    pending_beats.push_back(mk(CMD_WET, pmax, '0));           // does not end it
    pending_beats.push_back(mk(CMD_DRY, pmax, '1));
    pending_beats.push_back(mk(CMD_START, '0, '1));           // longest length, restarted
    pending_beats.push_back(mk(CMD_DRY, nmax, '0));
    pending_beats.push_back(mk(CMD_START, '0, 24'd2));
    pending_beats.push_back(mk(CMD_WET, 24'd1, '0));
    pending_beats.push_back(mk(CMD_DRY, nmax, '0));
    pending_beats.push_back(mk(CMD_DRY, nmax, '0));
    pending_beats.push_back(mk(CMD_START, '0, 24'd1));        // no wet samples
    pending_beats.push_back(mk(CMD_DRY, 24'h555555, '0));
    pending_beats.push_back(mk(CMD_START, '0, 24'h800000));
    pending_beats.push_back(mk(CMD_START, '0, 24'd4));
    repeat (4) pending_beats.push_back(mk(CMD_DRY, pmax, '0));
    run_random(300);
    settle();

    // random coefficients, with the long receiver hold-off
    for (int i = 0; i < NUM_REGS; i++)
      reg_write(reg_idx_t'(i), longint'($signed(COEF_W'($urandom))));
    hold_go = 1;
    run_random(380);
    settle();

    // extremes: every coefficient at the top, then at the bottom
    for (int i = 0; i < NUM_REGS; i++)
      reg_write(reg_idx_t'(i), (longint'(1) <<< (COEF_W - 1)) - 1);
    run_random(120);
    settle();
    for (int i = 0; i < NUM_REGS; i++)
      reg_write(reg_idx_t'(i), -(longint'(1) <<< (COEF_W - 1)));
    run_random(120);
    settle();

    // scaled-down random coefficients, no idling
    for (int i = 0; i < NUM_REGS; i++)
      reg_write(reg_idx_t'(i), longint'($signed(COEF_W'($urandom))) >>> $urandom_range(0, 4));
    quiet = 1;
    run_random(500);
    settle();

    if (mismatches == 0 && expected_meas.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
